FILE: rtl/rabi_pkg.sv
// Shared types, formats and constants for the two-level Rabi propagator.
`default_nettype none

package rabi_pkg;

  localparam int unsigned AMP_BITS = 16;

  // Register indexes of the configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DETUNING = 1'b1;

  localparam logic signed [15:0] COUPLING_RST = 16'sd4096;
  localparam logic signed [15:0] DETUNING_RST = 16'sd0;

  // Datapath widths
  localparam int unsigned SQ_W   = 40;  // radicand and root work word
  localparam int unsigned R16_W  = 20;  // generalized Rabi frequency, Q.16
  localparam int unsigned HALF_W = 39;  // half angle, Q.28
  localparam int unsigned X_W    = 30;  // folded angle and its square, Q.30
  localparam int unsigned P_W    = 31;  // series values in [0, 1], Q.30
  localparam int unsigned REM_W  = 50;  // divider remainder
  localparam int unsigned Q_W    = 31;  // divider quotient

  localparam logic [P_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam logic [30:0] TWO_PI_Q28     = 31'd1686629713;
  localparam logic [30:0] PI_Q28         = 31'd843314857;
  localparam logic [30:0] HALF_PI_Q28    = 31'd421657428;
  localparam logic [30:0] QUARTER_PI_Q28 = 31'd210828714;

  // Horner divisors, innermost term first
  localparam int unsigned HORNER_STEPS = 6;
  localparam int unsigned SIN_K [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_K [HORNER_STEPS] = '{132, 90, 56, 30, 12, 2};

  typedef struct packed {
    logic signed [AMP_BITS-1:0] amp0_re;
    logic signed [AMP_BITS-1:0] amp0_im;
    logic signed [AMP_BITS-1:0] amp1_re;
    logic signed [AMP_BITS-1:0] amp1_im;
    logic        [15:0]         elapsed_time;
  } in_t;

  typedef struct packed {
    logic signed [AMP_BITS-1:0] new_amp0_re;
    logic signed [AMP_BITS-1:0] new_amp0_im;
    logic signed [AMP_BITS-1:0] new_amp1_re;
    logic signed [AMP_BITS-1:0] new_amp1_im;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/rabi_sqrt_cell.sv
// One restoring step of the integer square root.
`default_nettype none

module rabi_sqrt_cell #(
  parameter int unsigned J = 0
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [rabi_pkg::SQ_W-1:0] n_i,
  input  wire logic [rabi_pkg::SQ_W-1:0] r_i,
  output logic      [rabi_pkg::SQ_W-1:0] n_o,
  output logic      [rabi_pkg::SQ_W-1:0] r_o
);
  import rabi_pkg::*;

  localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (2 * J);

  logic [SQ_W-1:0] rb;
  logic            ge;
  logic [SQ_W-1:0] n_d, n_q, r_d, r_q;

  always_comb begin
    rb  = r_i + Bit;
    ge  = (n_i >= rb);
    n_d = ge ? n_i - rb : n_i;
    r_d = ge ? (r_i >> 1) + Bit : (r_i >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign n_o = n_q;
  assign r_o = r_q;

endmodule

`default_nettype wire

FILE: rtl/rabi_mod_cell.sv
// One conditional subtract of 2*pi times a power of two from the half angle.
`default_nettype none

module rabi_mod_cell #(
  parameter int unsigned K = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [rabi_pkg::HALF_W-1:0] h_i,
  output logic      [rabi_pkg::HALF_W-1:0] h_o
);
  import rabi_pkg::*;

  localparam logic [HALF_W-1:0] Step = HALF_W'(TWO_PI_Q28) << K;

  logic [HALF_W-1:0] h_d, h_q;

  assign h_d = (h_i >= Step) ? h_i - Step : h_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_q <= h_d;
    end
  end

  assign h_o = h_q;

endmodule

`default_nettype wire

FILE: rtl/rabi_horner_cell.sv
// One Horner step p <- 1 - x2*p/K over three stages: product, reciprocal, fix-up.
`default_nettype none

module rabi_horner_cell #(
  parameter int unsigned K = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [rabi_pkg::X_W-1:0] x2_i,
  input  wire logic [rabi_pkg::P_W-1:0] p_i,
  output logic      [rabi_pkg::X_W-1:0] x2_o,
  output logic      [rabi_pkg::P_W-1:0] p_o
);
  import rabi_pkg::*;

  localparam logic [X_W-1:0] Recip = X_W'((64'd1 << 30) / K);
  localparam logic [7:0]     Kc    = 8'(K);

  logic [X_W+P_W-1:0] prod;
  logic [2*X_W-1:0]   mq;
  logic [X_W+7:0]     qk;
  logic [X_W-1:0]     rem, q;

  logic [X_W-1:0] v1_q, v2_q, q0_q;
  logic [X_W-1:0] x2a_q, x2b_q, x2c_q;
  logic [P_W-1:0] p_q;

  always_comb begin
    prod = x2_i * p_i;
    mq   = v1_q * Recip;
    qk   = q0_q * Kc;
    rem  = v2_q - qk[X_W-1:0];
    // reciprocal estimate is low by at most one
    q    = (rem >= X_W'(Kc)) ? q0_q + 1'b1 : q0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q  <= prod[2*X_W-1:X_W];
      x2a_q <= x2_i;
      v2_q  <= v1_q;
      q0_q  <= mq[2*X_W-1:X_W];
      x2b_q <= x2a_q;
      p_q   <= ONE_Q30 - P_W'(q);
      x2c_q <= x2b_q;
    end
  end

  assign x2_o = x2c_q;
  assign p_o  = p_q;

endmodule

`default_nettype wire

FILE: rtl/rabi_div_cell.sv
// One restoring step of the unsigned divide by the Rabi frequency.
`default_nettype none

module rabi_div_cell #(
  parameter int unsigned I = 0
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [rabi_pkg::REM_W-1:0] rem_i,
  input  wire logic [rabi_pkg::Q_W-1:0]   q_i,
  input  wire logic [rabi_pkg::R16_W-1:0] d_i,
  output logic      [rabi_pkg::REM_W-1:0] rem_o,
  output logic      [rabi_pkg::Q_W-1:0]   q_o
);
  import rabi_pkg::*;

  localparam logic [Q_W-1:0] QBit = Q_W'(1) << I;

  logic [REM_W:0]   dsh;
  logic             ge;
  logic [REM_W-1:0] rem_d, rem_q;
  logic [Q_W-1:0]   q_d, q_q;

  always_comb begin
    dsh   = (REM_W + 1)'(d_i) << I;
    ge    = ({1'b0, rem_i} >= dsh);
    rem_d = ge ? rem_i - dsh[REM_W-1:0] : rem_i;
    q_d   = ge ? (q_i | QBit) : q_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  assign rem_o = rem_q;
  assign q_o   = q_q;

endmodule

`default_nettype wire

FILE: rtl/two_level_rabi_propagator_top.sv
// Two-level Rabi propagator: pipelined root, angle reduction, series, divide, rotate.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------
//   cfg      | cfg_we_i               | cfg_index_i, cfg_data_i
//   in       | in_valid_i/in_ready_o  | in_data_i  (rabi_pkg::in_t)
//   out      | out_valid_o/out_ready_i| out_data_o (rabi_pkg::out_t)
//
// One transaction enters per cycle unless the output stalls. The cell chain holds
// 20 root steps, 9 reduction steps, 6 three-stage Horner steps and 31 divide steps
// plus glue stages. The whole chain advances together and holds while a result
// waits at the output register. Reset clears the stage valid bits and loads
// coupling 1.0 and detuning 0.
`default_nettype none

module two_level_rabi_propagator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rabi_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rabi_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rabi_pkg::out_t                     out_data_o
);
  import rabi_pkg::*;

  localparam int unsigned NSQ    = 20;
  localparam int unsigned NMOD   = 9;
  localparam int unsigned NDIV   = Q_W;
  localparam int unsigned ST_SQ  = NSQ;
  localparam int unsigned ST_H   = ST_SQ + 1;
  localparam int unsigned ST_MOD = ST_H + NMOD;
  localparam int unsigned ST_F   = ST_MOD + 1;
  localparam int unsigned ST_X2  = ST_F + 1;
  localparam int unsigned ST_HN  = ST_X2 + 3 * HORNER_STEPS;
  localparam int unsigned ST_SV  = ST_HN + 1;
  localparam int unsigned ST_SC  = ST_SV + 1;
  localparam int unsigned ST_NUM = ST_SC + 1;
  localparam int unsigned ST_DV  = ST_NUM + NDIV;
  localparam int unsigned ST_AB  = ST_DV + 1;
  localparam int unsigned ST_PR  = ST_AB + 1;
  localparam int unsigned NST    = ST_PR + 2;
  localparam int unsigned PRD_W  = 32 + AMP_BITS;
  localparam int unsigned ACC_W  = PRD_W + 2;

  typedef struct packed {
    in_t                item;
    logic signed [15:0] om;
    logic signed [15:0] de;
    logic [R16_W-1:0]   r16;
    logic               zero;
    logic               sneg;
    logic               cneg;
    logic               swap;
    logic               nega;
    logic               negb;
    logic [X_W-1:0]     x;
    logic signed [31:0] c;
  } side_t;

  function automatic logic signed [AMP_BITS-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] hi, lo;
    logic signed [AMP_BITS-1:0] res;
    rnd = (acc + (ACC_W'(1) <<< 29)) >>> 30;
    hi  = ACC_W'((64'sd1 <<< (AMP_BITS - 1)) - 64'sd1);
    lo  = -hi - ACC_W'(1);
    if (rnd > hi) begin
      res = hi[AMP_BITS-1:0];
    end else if (rnd < lo) begin
      res = lo[AMP_BITS-1:0];
    end else begin
      res = rnd[AMP_BITS-1:0];
    end
    return res;
  endfunction

  // configuration
  logic signed [15:0] om_q, de_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      om_q <= COUPLING_RST;
      de_q <= DETUNING_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COUPLING: om_q <= cfg_data_i;
        REG_DETUNING: de_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control: advance unless a result is stuck at the output
  logic           en;
  logic [NST-1:0] vld_q;

  assign en          = out_ready_i | ~vld_q[NST-1];
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  side_t sd_d [0:ST_PR];
  side_t sd_q [0:ST_PR];

  // radicand
  logic signed [31:0] om2, de2;
  logic [31:0]        ssum;
  logic [SQ_W-1:0]    n0_q;

  always_comb begin
    om2  = om_q * om_q;
    de2  = de_q * de_q;
    ssum = $unsigned(om2) + $unsigned(de2);
  end

  logic [SQ_W-1:0] sq_n [0:NSQ];
  logic [SQ_W-1:0] sq_r [0:NSQ];

  assign sq_n[0] = n0_q;
  assign sq_r[0] = '0;

  for (genvar m = 0; m < NSQ; m++) begin : g_sqrt
    rabi_sqrt_cell #(.J(NSQ - 1 - m)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (sq_n[m]),
      .r_i   (sq_r[m]),
      .n_o   (sq_n[m+1]),
      .r_o   (sq_r[m+1])
    );
  end

  logic [R16_W-1:0]  r16;
  logic [35:0]       rt;
  logic [HALF_W-1:0] half_q;

  assign r16 = sq_r[NSQ][R16_W-1:0];
  assign rt  = r16 * sd_q[ST_SQ].item.elapsed_time;

  logic [HALF_W-1:0] mod_h [0:NMOD];

  assign mod_h[0] = half_q;

  for (genvar m = 0; m < NMOD; m++) begin : g_mod
    rabi_mod_cell #(.K(NMOD - 1 - m)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .h_i   (mod_h[m]),
      .h_o   (mod_h[m+1])
    );
  end

  // fold into [0, pi/4]
  logic [30:0] am, a1, a2, a3;
  logic        f_sneg, f_cneg, f_swap;

  always_comb begin
    am     = mod_h[NMOD][30:0];
    f_sneg = (am > PI_Q28);
    a1     = f_sneg ? TWO_PI_Q28 - am : am;
    f_cneg = (a1 > HALF_PI_Q28);
    a2     = f_cneg ? PI_Q28 - a1 : a1;
    f_swap = (a2 > QUARTER_PI_Q28);
    a3     = f_swap ? HALF_PI_Q28 - a2 : a2;
  end

  logic [2*X_W-1:0] xx;
  logic [X_W-1:0]   x2_q;

  assign xx = sd_q[ST_F].x * sd_q[ST_F].x;

  logic [X_W-1:0] hs_x2 [0:HORNER_STEPS];
  logic [P_W-1:0] hs_p  [0:HORNER_STEPS];
  logic [X_W-1:0] hc_x2 [0:HORNER_STEPS];
  logic [P_W-1:0] hc_p  [0:HORNER_STEPS];

  assign hs_x2[0] = x2_q;
  assign hs_p[0]  = ONE_Q30;
  assign hc_x2[0] = x2_q;
  assign hc_p[0]  = ONE_Q30;

  for (genvar m = 0; m < HORNER_STEPS; m++) begin : g_horner
    rabi_horner_cell #(.K(SIN_K[m])) u_sin (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (hs_x2[m]),
      .p_i   (hs_p[m]),
      .x2_o  (hs_x2[m+1]),
      .p_o   (hs_p[m+1])
    );
    rabi_horner_cell #(.K(COS_K[m])) u_cos (
      .clk_i (clk_i),
      .en_i  (en),
      .x2_i  (hc_x2[m]),
      .p_i   (hc_p[m]),
      .x2_o  (hc_x2[m+1]),
      .p_o   (hc_p[m+1])
    );
  end

  logic [X_W+P_W-1:0] xs;
  logic [P_W-1:0]     sv_q, cv_q;

  assign xs = sd_q[ST_HN].x * hs_p[HORNER_STEPS];

  // octant signs and swap
  logic [P_W-1:0]     sm, cm;
  logic signed [31:0] s_v, c_v, s_q;

  always_comb begin
    sm  = sd_q[ST_SV].swap ? cv_q : sv_q;
    cm  = sd_q[ST_SV].swap ? sv_q : cv_q;
    s_v = sd_q[ST_SV].sneg ? -$signed({1'b0, sm}) : $signed({1'b0, sm});
    c_v = sd_q[ST_SV].cneg ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
  end

  // dividend magnitudes
  logic signed [31:0] s_abs;
  logic signed [16:0] om_x, de_x, om_abs, de_abs;
  logic [46:0]        pa, pb;
  logic [REM_W-1:0]   num_a_q, num_b_q;

  always_comb begin
    s_abs  = s_q[31] ? -s_q : s_q;
    om_x   = 17'(sd_q[ST_SC].om);
    de_x   = 17'(sd_q[ST_SC].de);
    om_abs = om_x[16] ? -om_x : om_x;
    de_abs = de_x[16] ? -de_x : de_x;
    pa     = s_abs[30:0] * om_abs[15:0];
    pb     = s_abs[30:0] * de_abs[15:0];
  end

  logic [REM_W-1:0] dv_ra [0:NDIV];
  logic [Q_W-1:0]   dv_qa [0:NDIV];
  logic [REM_W-1:0] dv_rb [0:NDIV];
  logic [Q_W-1:0]   dv_qb [0:NDIV];

  assign dv_ra[0] = num_a_q;
  assign dv_qa[0] = '0;
  assign dv_rb[0] = num_b_q;
  assign dv_qb[0] = '0;

  for (genvar m = 0; m < NDIV; m++) begin : g_div
    rabi_div_cell #(.I(NDIV - 1 - m)) u_a (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (dv_ra[m]),
      .q_i   (dv_qa[m]),
      .d_i   (sd_q[ST_NUM+m].r16),
      .rem_o (dv_ra[m+1]),
      .q_o   (dv_qa[m+1])
    );
    rabi_div_cell #(.I(NDIV - 1 - m)) u_b (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (dv_rb[m]),
      .q_i   (dv_qb[m]),
      .d_i   (sd_q[ST_NUM+m].r16),
      .rem_o (dv_rb[m+1]),
      .q_o   (dv_qb[m+1])
    );
  end

  // signed coefficients; zero frequency passes the state through
  logic signed [31:0] qa_s, qb_s, a_v, b_v, a_q, b_q;

  always_comb begin
    qa_s = $signed({1'b0, dv_qa[NDIV]});
    qb_s = $signed({1'b0, dv_qb[NDIV]});
    if (sd_q[ST_DV].zero) begin
      a_v = '0;
      b_v = '0;
    end else begin
      a_v = sd_q[ST_DV].nega ? -qa_s : qa_s;
      b_v = sd_q[ST_DV].negb ? -qb_s : qb_s;
    end
  end

  // rotation products
  logic signed [PRD_W-1:0] c0r_q, c0i_q, c1r_q, c1i_q;
  logic signed [PRD_W-1:0] b0r_q, b0i_q, b1r_q, b1i_q;
  logic signed [PRD_W-1:0] a0r_q, a0i_q, a1r_q, a1i_q;
  out_t                    out_q;

  always_comb begin
    sd_d[0]      = '0;
    sd_d[0].item = in_data_i;
    sd_d[0].om   = om_q;
    sd_d[0].de   = de_q;
    for (int k = 1; k <= ST_PR; k++) begin
      sd_d[k] = sd_q[k-1];
    end
    sd_d[ST_H].r16   = r16;
    sd_d[ST_H].zero  = (r16 == '0);
    sd_d[ST_F].sneg  = f_sneg;
    sd_d[ST_F].cneg  = f_cneg;
    sd_d[ST_F].swap  = f_swap;
    sd_d[ST_F].x     = {a3[27:0], 2'b00};
    sd_d[ST_SC].c    = c_v;
    sd_d[ST_NUM].nega = s_q[31] ^ sd_q[ST_SC].om[15];
    sd_d[ST_NUM].negb = s_q[31] ^ sd_q[ST_SC].de[15];
    if (sd_q[ST_DV].zero) begin
      sd_d[ST_AB].c = 32'(ONE_Q30);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q    <= sd_d;
      n0_q    <= {ssum, 8'd0};
      half_q  <= {rt, 3'b000};
      x2_q    <= xx[2*X_W-1:X_W];
      sv_q    <= xs[X_W+P_W-1:X_W];
      cv_q    <= hc_p[HORNER_STEPS];
      s_q     <= s_v;
      num_a_q <= {pa[45:0], 4'b0000};
      num_b_q <= {pb[45:0], 4'b0000};
      a_q     <= a_v;
      b_q     <= b_v;
      c0r_q   <= sd_q[ST_AB].c * sd_q[ST_AB].item.amp0_re;
      c0i_q   <= sd_q[ST_AB].c * sd_q[ST_AB].item.amp0_im;
      c1r_q   <= sd_q[ST_AB].c * sd_q[ST_AB].item.amp1_re;
      c1i_q   <= sd_q[ST_AB].c * sd_q[ST_AB].item.amp1_im;
      b0r_q   <= b_q * sd_q[ST_AB].item.amp0_re;
      b0i_q   <= b_q * sd_q[ST_AB].item.amp0_im;
      b1r_q   <= b_q * sd_q[ST_AB].item.amp1_re;
      b1i_q   <= b_q * sd_q[ST_AB].item.amp1_im;
      a0r_q   <= a_q * sd_q[ST_AB].item.amp0_re;
      a0i_q   <= a_q * sd_q[ST_AB].item.amp0_im;
      a1r_q   <= a_q * sd_q[ST_AB].item.amp1_re;
      a1i_q   <= a_q * sd_q[ST_AB].item.amp1_im;
      out_q.new_amp0_re <= finish(ACC_W'(c0r_q) + ACC_W'(b0i_q) + ACC_W'(a1i_q));
      out_q.new_amp0_im <= finish(ACC_W'(c0i_q) - ACC_W'(b0r_q) - ACC_W'(a1r_q));
      out_q.new_amp1_re <= finish(ACC_W'(a0i_q) + ACC_W'(c1r_q) - ACC_W'(b1i_q));
      out_q.new_amp1_im <= finish(ACC_W'(c1i_q) - ACC_W'(a0r_q) + ACC_W'(b1r_q));
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
